### rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg: shared constants and types for the recursive bisection split
// Field widths, stack geometry and the command/status bundles exchanged
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Width of one coordinate field on the stream ports.
  localparam int FIELD_W       = 32;
  // Width of the part count register and of stored part counts.
  localparam int PARTS_W       = 7;
  // Number of axes of a box.
  localparam int NUM_AXES      = 3;
  // Pending second halves: one per bisection level at most.
  localparam int STACK_DEPTH   = 7;
  localparam int SP_W          = 3;
  // Stream payload: three origins and three sizes.
  localparam int TDATA_W       = 2 * NUM_AXES * FIELD_W;
  // Defaults for the top-level parameters.
  localparam int MAX_PARTS_DEF = 64;
  localparam int COORD_W_DEF   = 32;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new box and start the scan pass
    logic restart;  // rewind to the captured box for the emit pass
    logic step;     // process the current node (split, or pop after a leaf)
    logic emit;     // write the current leaf into the output register
  } rbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic leaf;       // current node holds one part
    logic stk_empty;  // no pending second halves
    logic out_free;   // output register can take a request this cycle
  } rbs_sts_t;

endpackage

### rtl/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath: box registers, split unit, pending stack and output register
// Holds the current node, bisects it along its longest axis, keeps pending
// second halves on a small stack and presents leaves on the result stream.
// ----------------------------------------------------------------------------
module rbs_datapath
  import rbs_pkg::*;
#(
  parameter int MAX_PARTS = MAX_PARTS_DEF,
  parameter int COORD_W   = COORD_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write
  input  logic                 cfg_valid,
  input  logic [PARTS_W-1:0]   cfg_data,
  // Input box, fields from the lowest bit up:
  // origin_x, origin_y, origin_z, size_x, size_y, size_z
  input  logic [TDATA_W-1:0]   in_tdata,
  // Control
  input  rbs_cmd_t             cmd,
  output rbs_sts_t             sts,
  // Result stream, fields from the lowest bit up:
  // sub_origin_x, sub_origin_y, sub_origin_z, sub_size_x, sub_size_y, sub_size_z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);

  // Configuration and control registers
  logic [PARTS_W-1:0] part_count_r;
  logic [SP_W-1:0]    sp_r;
  logic               out_valid_r;

  // Captured input box and current node
  logic [COORD_W-1:0] box_org_r [NUM_AXES];
  logic [COORD_W-1:0] box_sz_r  [NUM_AXES];
  logic [COORD_W-1:0] cur_org_r [NUM_AXES];
  logic [COORD_W-1:0] cur_sz_r  [NUM_AXES];
  logic [PARTS_W-1:0] cur_parts_r;
  logic               err_r;

  // Pending second halves
  logic [COORD_W-1:0] stk_org_r [STACK_DEPTH][NUM_AXES];
  logic [COORD_W-1:0] stk_sz_r  [STACK_DEPTH][NUM_AXES];
  logic [PARTS_W-1:0] stk_parts_r [STACK_DEPTH];

  // Output register
  logic [TDATA_W-1:0] out_data_r;
  logic               out_last_r;
  logic               out_err_r;

  // Split unit signals
  logic [PARTS_W-1:0] parts_sat;
  logic [1:0]         axis;
  logic [COORD_W-1:0] cut_sz;
  logic [COORD_W-1:0] hi_sz;
  logic [COORD_W-1:0] lo_sz;
  logic [COORD_W-1:0] cut_org2;
  logic [PARTS_W-1:0] lo_parts;
  logic [PARTS_W-1:0] hi_parts;
  logic               thin_cut;
  logic [SP_W-1:0]    top_idx;

  // Part count with zero taken as one and large values saturated.
  always_comb begin
    if (part_count_r == '0) begin
      parts_sat = PARTS_W'(1);
    end else if (part_count_r > PARTS_W'(MAX_PARTS)) begin
      parts_sat = PARTS_W'(MAX_PARTS);
    end else begin
      parts_sat = part_count_r;
    end
  end

  // Longest axis, lower axis wins a tie, then the halves along it.
  always_comb begin
    axis = AXIS_X;
    if (cur_sz_r[1] > cur_sz_r[0]) begin
      axis = AXIS_Y;
    end
    unique case (axis)
      AXIS_Y:  cut_sz = cur_sz_r[1];
      default: cut_sz = cur_sz_r[0];
    endcase
    if (cur_sz_r[2] > cut_sz) begin
      axis   = AXIS_Z;
      cut_sz = cur_sz_r[2];
    end
    lo_sz    = cut_sz >> 1;
    hi_sz    = cut_sz - lo_sz;
    thin_cut = (cut_sz < COORD_W'(2));
    unique case (axis)
      AXIS_Y:  cut_org2 = cur_org_r[1] + hi_sz;
      AXIS_Z:  cut_org2 = cur_org_r[2] + hi_sz;
      default: cut_org2 = cur_org_r[0] + hi_sz;
    endcase
    lo_parts = cur_parts_r >> 1;
    hi_parts = cur_parts_r - lo_parts;
  end

  assign top_idx = sp_r - SP_W'(1);

  // Status toward the controller
  always_comb begin
    sts.leaf      = (cur_parts_r <= PARTS_W'(1));
    sts.stk_empty = (sp_r == '0);
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Control state: register, stack pointer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= PARTS_W'(1);
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        part_count_r <= cfg_data;
      end
      if (cmd.load || cmd.restart) begin
        sp_r <= '0;
      end else if (cmd.step) begin
        if (sts.leaf) begin
          if (!sts.stk_empty) begin
            sp_r <= top_idx;
          end
        end else begin
          sp_r <= sp_r + SP_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: current node, captured box, stack and output data.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_org_r[a] <= in_tdata[a*FIELD_W +: COORD_W];
        box_sz_r[a]  <= in_tdata[(NUM_AXES+a)*FIELD_W +: COORD_W];
        cur_org_r[a] <= in_tdata[a*FIELD_W +: COORD_W];
        cur_sz_r[a]  <= in_tdata[(NUM_AXES+a)*FIELD_W +: COORD_W];
      end
      cur_parts_r <= parts_sat;
      err_r       <= 1'b0;
    end else if (cmd.restart) begin
      cur_org_r   <= box_org_r;
      cur_sz_r    <= box_sz_r;
      cur_parts_r <= parts_sat;
    end else if (cmd.step) begin
      if (sts.leaf) begin
        // Leaf done: continue with the most recent pending half.
        if (!sts.stk_empty) begin
          cur_org_r   <= stk_org_r[top_idx];
          cur_sz_r    <= stk_sz_r[top_idx];
          cur_parts_r <= stk_parts_r[top_idx];
        end
      end else begin
        // Split: keep the first half, push the second half.
        for (int a = 0; a < NUM_AXES; a++) begin
          stk_org_r[sp_r][a] <= (axis == 2'(a)) ? cut_org2 : cur_org_r[a];
          stk_sz_r[sp_r][a]  <= (axis == 2'(a)) ? lo_sz : cur_sz_r[a];
          if (axis == 2'(a)) begin
            cur_sz_r[a] <= hi_sz;
          end
        end
        stk_parts_r[sp_r] <= lo_parts;
        cur_parts_r       <= hi_parts;
        err_r             <= err_r | thin_cut;
      end
    end
    if (cmd.emit) begin
      out_data_r <= {FIELD_W'(cur_sz_r[2]), FIELD_W'(cur_sz_r[1]), FIELD_W'(cur_sz_r[0]),
                     FIELD_W'(cur_org_r[2]), FIELD_W'(cur_org_r[1]), FIELD_W'(cur_org_r[0])};
      out_last_r <= sts.stk_empty;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

### rtl/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl: sequencer for the recursive bisection split
// Runs a silent scan pass that settles the error flag, then an emit pass that
// walks the same tree again and sends each leaf to the output register.
// ----------------------------------------------------------------------------
module rbs_ctrl
  import rbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  rbs_sts_t sts,
  output rbs_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;

  // Commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.leaf && sts.stk_empty) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!sts.leaf) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
          cmd.emit = 1'b1;
          if (sts.stk_empty) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

### rtl/recursive_bisection_split.sv
// ----------------------------------------------------------------------------
// recursive_bisection_split: split one 3D box into part_count sub-boxes
// Recursive coordinate bisection along the longest axis, leaves sent
// depth-first with a last marker and a run-wide cut error flag.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Content
//  in_      slave      in_tvalid/in_tready  box origin and size per axis
//  out_     master     out_tvalid/out_tready  one sub-box, tlast, tuser = cut error
//  cfg_     slave      cfg_valid/cfg_ready  part_count (always ready)
//
//  One node of the split tree goes through the single split unit per cycle,
//  and the tree is walked once to settle the error flag and once more to send
//  the leaves. Output stalls hold up the second walk only.
//  Reset is synchronous and active low; part_count resets to one.
//  A new box is taken as soon as the last leaf sits in the output register.
//
module recursive_bisection_split
  import rbs_pkg::*;
#(
  parameter int MAX_PARTS = MAX_PARTS_DEF,
  parameter int COORD_W   = COORD_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: part_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PARTS_W-1:0] cfg_data,
  // Input boxes, from the lowest bit up:
  // origin_x, origin_y, origin_z, size_x, size_y, size_z
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,
  // Sub-boxes, from the lowest bit up:
  // sub_origin_x, sub_origin_y, sub_origin_z, sub_size_x, sub_size_y, sub_size_z
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,   // last_part
  output logic               out_tuser    // cut_error
);

  rbs_cmd_t cmd;
  rbs_sts_t sts;

  assign cfg_ready = 1'b1;

  rbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbs_datapath #(
    .MAX_PARTS (MAX_PARTS),
    .COORD_W   (COORD_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A taken box makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready right after a box was taken");

  // Only a leaf is ever sent, and only into a free output register.
  a_emit_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.leaf && sts.out_free)
    else $error("emit of a non-leaf node or into a busy output register");

  // A sent leaf shows up on the output in the next cycle.
  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted leaf not presented on the output");

  // Loading a new box never coincides with processing a node.
  a_load_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.step && !cmd.restart && !cmd.emit)
    else $error("box load overlaps node processing");

endmodule
